// File: design/bdsl_pkg.sv
// Package for the button debounce / short-long press core.
// Holds the button count, register indexes and the request and event types.
// No dependencies.
package bdsl_pkg;

  localparam int BUTTONS = 4;
  localparam int IDX_W   = 2;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TIME_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd800;

  typedef struct packed {
    logic [BUTTONS-1:0] button_levels;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] button_index;
    logic             event_kind;
    logic             last_event;
  } out_item_t;

  typedef struct packed {
    logic hit;
    logic kind;
  } lane_evt_t;

endpackage

// File: design/bdsl_lane.sv
// One button lane: debounce state, press timing and event detection.
// Depends on bdsl_pkg.
module bdsl_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        level,
  input  logic [bdsl_pkg::TIME_W-1:0] now_ms,
  input  logic [bdsl_pkg::CFG_W-1:0]  debounce_time,
  input  logic [bdsl_pkg::CFG_W-1:0]  long_press_time,
  output bdsl_pkg::lane_evt_t         evt
);
  import bdsl_pkg::*;

  logic              acc_level;
  logic [TIME_W-1:0] last_change;
  logic [TIME_W-1:0] press_start;
  logic              long_rep;

  logic              change;
  logic              press_acc;
  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] press_start_next;
  logic              long_rep_mid;
  logic              long_hit;
  logic              short_hit;
  logic [TIME_W-1:0] held;

  always_comb begin
    since_change     = now_ms - last_change;
    change           = (level != acc_level) &&
                       (since_change >= {{(TIME_W-CFG_W){1'b0}}, debounce_time});
    press_acc        = change && !level;
    press_start_next = press_acc ? now_ms : press_start;
    long_rep_mid     = press_acc ? 1'b0 : long_rep;
    short_hit        = change && level && !long_rep;
    // long press follows the raw level, measured from the accepted press time
    held             = now_ms - press_start_next;
    long_hit         = !level && !long_rep_mid &&
                       (held >= {{(TIME_W-CFG_W){1'b0}}, long_press_time});
    evt.hit          = short_hit || long_hit;
    evt.kind         = long_hit ? KIND_LONG : KIND_SHORT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_level   <= 1'b1;
      last_change <= '0;
      press_start <= '0;
      long_rep    <= 1'b0;
    end else if (load) begin
      if (change) begin
        acc_level   <= level;
        last_change <= now_ms;
      end
      press_start <= press_start_next;
      long_rep    <= long_rep_mid || long_hit;
    end
  end

endmodule

// File: design/bdsl_merge.sv
// Merging stage: collects the lane events of one poll and emits them in
// button order through an output register. Depends on bdsl_pkg.
module bdsl_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  bdsl_pkg::lane_evt_t [bdsl_pkg::BUTTONS-1:0] lane_evt,
  output logic                                  idle,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output bdsl_pkg::out_item_t                   out_data
);
  import bdsl_pkg::*;

  logic [BUTTONS-1:0] pend;
  logic [BUTTONS-1:0] kinds;
  logic [BUTTONS-1:0] pend_after;
  logic [BUTTONS-1:0] low_bit;
  logic [IDX_W-1:0]   low_idx;
  logic               slot_free;
  logic               take;

  always_comb begin
    low_bit = '0;
    low_idx = '0;
    for (int i = BUTTONS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        low_bit    = '0;
        low_bit[i] = 1'b1;
        low_idx    = IDX_W'(i);
      end
    end
    slot_free  = !out_valid || out_ready;
    take       = slot_free && (pend != '0);
    pend_after = take ? (pend & ~low_bit) : pend;
    // next poll may come in once the last pending event moves to the output
    idle       = (pend_after == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        for (int i = 0; i < BUTTONS; i++) begin
          pend[i] <= lane_evt[i].hit;
        end
      end else begin
        pend <= pend_after;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < BUTTONS; i++) begin
        kinds[i] <= lane_evt[i].kind;
      end
    end
    if (take) begin
      out_data.button_index <= low_idx;
      out_data.event_kind   <= |(kinds & low_bit);
      out_data.last_event   <= (pend_after == '0);
    end
  end

endmodule

// File: design/button_debounce_short_long_press_core.sv
// A poll request carries the active-low levels of all buttons and a wrapping
// millisecond time; each button lane debounces its level and detects short
// and long presses in the accept cycle, and the merging stage sends out at
// most one event per button in button order, flagging the last one. A
// poll's events are captured in the pending register and then move into
// the output register one event per cycle while out_ready is high; the
// next poll is accepted in the cycle its predecessor's last event moves
// into the output register, and polls that cause no events are accepted
// every cycle. Registers: 0 debounce time, 1 long press time. The user must
// write them only while the block is idle; the block does not enforce it.
// Depends on bdsl_pkg, bdsl_lane and bdsl_merge.
module button_debounce_short_long_press_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bdsl_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bdsl_pkg::out_item_t            out_data,
  input  logic                           cfg_wen,
  input  logic [bdsl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdsl_pkg::CFG_W-1:0]     cfg_wdata
);
  import bdsl_pkg::*;

  logic [CFG_W-1:0] debounce_time;
  logic [CFG_W-1:0] long_press_time;
  logic             load;
  lane_evt_t [BUTTONS-1:0] lane_evt;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RESET;
      long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_time   <= cfg_wdata;
        REG_LONG_PRESS: long_press_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign load = in_valid && in_ready;

  for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
    bdsl_lane u_lane (
      .clk             (clk),
      .rst             (rst),
      .load            (load),
      .level           (in_data.button_levels[g]),
      .now_ms          (in_data.now_ms),
      .debounce_time   (debounce_time),
      .long_press_time (long_press_time),
      .evt             (lane_evt[g])
    );
  end

  bdsl_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .lane_evt  (lane_evt),
    .idle      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
